@@ hdl/bbf_pkg.sv @@
// Shared types, codes and constants for the bilinear biquad filter.
`timescale 1ns / 1ps

package bbf_pkg;

    // filter_mode codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_LPF1  = 3'd1;
    localparam logic [2:0] MODE_HPF1  = 3'd2;
    localparam logic [2:0] MODE_LPF2  = 3'd3;
    localparam logic [2:0] MODE_HPF2  = 3'd4;
    localparam logic [2:0] MODE_DERIV = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_CUT1   = 2'd1;
    localparam logic [1:0] REG_CUT2   = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    localparam logic [63:0] PI_Q25      = 64'd105414357;
    localparam logic [63:0] TWO_E9      = 64'd2000000000;
    localparam logic [63:0] ONE_Q48     = 64'h0001_0000_0000_0000;
    localparam logic [63:0] U_CAP       = 64'h0000_0000_8000_0000;
    localparam logic [63:0] P_CAP       = 64'h0000_0010_0000_0000;
    localparam logic [6:0]  DIV_FULL_IT = 7'd64;

    // 2e9 = 2^10 * 5^9; floor(2^52 / 5^9) for the reciprocal estimate
    localparam logic [63:0] FIVE_P9     = 64'd1953125;
    localparam logic [63:0] RECIP_5P9   = 64'd2305843009;

    typedef struct packed {
        logic        start;
        logic [63:0] rem0;   // starting remainder, below den
        logic [63:0] num;    // bits shifted in, MSB first
        logic [63:0] den;
        logic [6:0]  iters;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hdl/bbf_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bbf_div
    import bbf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_quo;

    logic [64:0] n_trial;
    logic [64:0] n_diff;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_num[63]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.rem0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= i_req.iters;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[63:0] : n_trial[63:0];
                r_num <= {r_num[62:0], 1'b0};
                r_quo <= {r_quo[62:0], n_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ hdl/bilinear_biquad_filter.sv @@
// Top level: coefficient derivation sequencer and direct-form-I biquad datapath.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | tvalid / tready         | tdata: sample_in
//  m_axis    | out       | tvalid / tready         | tdata: sample_out, tuser: saturated
//  cfg       | in        | i_cfg_wr_en             | i_cfg_addr, i_cfg_wdata
//
// A sample passes through accept, 7 multiply-accumulate steps on the shared 33x33
// multiplier, and finish. The first sample after reset or a register write also derives
// the coefficients: in an undefined mode it only stores zero coefficients, otherwise the
// derivation runs mostly on the serial divider that yields one quotient bit per cycle. Reset is
// synchronous and clears history and coefficients.
// A result waits in the output register; the finish step holds until it is free.
`timescale 1ns / 1ps

module bilinear_biquad_filter
    import bbf_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // [SB-1:0] sample_in
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // [SB-1:0] sample_out
    output logic                                  m_axis_tuser,  // [0] saturated
    input  logic                                  i_cfg_wr_en,
    input  logic [1:0]                            i_cfg_addr,
    input  logic [29:0]                           i_cfg_wdata
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic signed [35:0] ONE_COEF = 36'sd1 <<< COEF_FRAC_BITS;
    localparam logic [63:0] ONE_Q = 64'd1 << COEF_FRAC_BITS;
    localparam logic [6:0]  FRAC_IT = 7'(COEF_FRAC_BITS);
    localparam logic signed [67:0] HALF = 68'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [67:0] SMAX = (68'sd1 <<< (SAMPLE_BITS - 1)) - 68'sd1;
    localparam logic signed [67:0] SMIN = -SMAX - 68'sd1;
    localparam logic signed [67:0] Y32MAX = 68'sd2147483647;
    localparam logic signed [67:0] Y32MIN = -68'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7, S_U8, S_U9,
        S_UFIX, S_UCAP,
        S_DIVW, S_C1, S_C1P, S_D1, S_D2, S_D3,
        S_P0, S_P1, S_P2, S_P3, S_HL, S_LST,
        S_STORE, S_MAC, S_FIN
    } t_state;

    t_state r_state;
    t_state r_ret;

    logic [2:0]  r_mode;
    logic [19:0] r_cut1;
    logic [19:0] r_cut2;
    logic [29:0] r_period;
    logic        r_cvalid;

    logic signed [32:0] r_ma;
    logic signed [32:0] r_mb;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;

    logic        r_sel;
    logic [35:0] r_pp;
    logic [63:0] r_rem;
    logic [31:0] r_u;
    logic [31:0] r_v;
    logic [63:0] r_q;
    logic [63:0] r_p2;
    logic [63:0] r_dd;
    logic [30:0] r_c;
    logic [30:0] r_h;
    logic [30:0] r_l;
    logic [30:0] r_b0;

    logic signed [31:0] r_coef [5];

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_x2;
    logic signed [31:0]            r_y1;
    logic signed [31:0]            r_y2;
    logic [2:0]                    r_k;

    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_odata;
    logic                   r_osat;

    t_div_req r_dreq;
    t_div_rsp w_drsp;

    logic [19:0]        n_f;
    logic [63:0]        n_pn;
    logic [63:0]        n_xf;
    logic [63:0]        n_fn;
    logic [63:0]        n_fd;
    logic [63:0]        n_ucap;
    logic signed [32:0] n_mac_a;
    logic signed [32:0] n_mac_b;
    logic signed [67:0] n_sum;
    logic signed [67:0] n_y;
    logic signed [67:0] n_ys;
    logic signed [67:0] n_y32;
    logic signed [35:0] n_cf [5];
    logic signed [35:0] n_c36;
    logic signed [35:0] n_h36;
    logic signed [35:0] n_l36;
    logic signed [35:0] n_b036;
    logic               n_out_free;
    logic               n_second;
    logic               n_defined;

    bbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    always_comb begin
        n_f      = r_sel ? r_cut2 : r_cut1;
        n_pn     = r_acc[63:0] + r_prod[63:0];
        n_second = (r_mode == MODE_LPF2) || (r_mode == MODE_HPF2);
        n_defined = (r_mode == MODE_LPF1) || (r_mode == MODE_HPF1) || n_second
                 || (r_mode == MODE_DERIV);
        n_xf     = (r_mode == MODE_DERIV) ? {9'd0, r_u, 23'd0} : {8'd0, r_u, 24'd0};
        n_ucap   = (r_q > U_CAP) ? U_CAP : r_q;

        // operands of the fractional division launched in this state
        unique case (r_state)
            S_P3: begin
                n_fn = r_p2;
                n_fd = r_dd;
            end
            S_HL: begin
                n_fn = ONE_Q48;
                n_fd = r_dd;
            end
            default: begin
                n_fn = n_xf;
                n_fd = ONE_Q48 + n_xf;
            end
        endcase

        case (r_k)
            3'd0: begin
                n_mac_a = 33'(r_coef[0]);
                n_mac_b = 33'(r_x);
            end
            3'd1: begin
                n_mac_a = 33'(r_coef[1]);
                n_mac_b = 33'(r_x1);
            end
            3'd2: begin
                n_mac_a = 33'(r_coef[2]);
                n_mac_b = 33'(r_x2);
            end
            3'd3: begin
                n_mac_a = 33'sd0 - 33'(r_coef[3]);
                n_mac_b = 33'(r_y1);
            end
            3'd4: begin
                n_mac_a = 33'sd0 - 33'(r_coef[4]);
                n_mac_b = 33'(r_y2);
            end
            default: begin
                n_mac_a = '0;
                n_mac_b = '0;
            end
        endcase

        n_sum = r_acc + HALF;
        n_y   = n_sum >>> COEF_FRAC_BITS;
        n_ys  = (n_y > SMAX) ? SMAX : ((n_y < SMIN) ? SMIN : n_y);
        n_y32 = (n_y > Y32MAX) ? Y32MAX : ((n_y < Y32MIN) ? Y32MIN : n_y);

        n_c36  = $signed({5'd0, r_c});
        n_h36  = $signed({5'd0, r_h});
        n_l36  = $signed({5'd0, r_l});
        n_b036 = $signed({5'd0, r_b0});
        for (int i = 0; i < 5; i++) begin
            n_cf[i] = '0;
        end
        unique case (r_mode)
            MODE_LPF1: begin
                n_cf[0] = n_c36;
                n_cf[1] = n_c36 + n_c36;
                n_cf[2] = n_c36;
                n_cf[3] = n_c36 + n_c36;
                n_cf[4] = n_c36 + n_c36 - ONE_COEF;
            end
            MODE_HPF1: begin
                n_cf[0] = ONE_COEF - n_c36;
                n_cf[2] = n_c36 - ONE_COEF;
                n_cf[3] = n_c36 + n_c36;
                n_cf[4] = n_c36 + n_c36 - ONE_COEF;
            end
            MODE_DERIV: begin
                n_cf[0] = n_b036;
                n_cf[2] = -n_b036;
                n_cf[3] = n_c36 + n_c36;
                n_cf[4] = n_c36 + n_c36 - ONE_COEF;
            end
            MODE_LPF2: begin
                n_cf[0] = n_h36;
                n_cf[1] = n_h36 + n_h36;
                n_cf[2] = n_h36;
                n_cf[3] = n_h36 + n_h36 - n_l36 - n_l36;
                n_cf[4] = n_h36 + n_h36 + n_l36 + n_l36 - ONE_COEF;
            end
            MODE_HPF2: begin
                n_cf[0] = n_l36;
                n_cf[1] = -(n_l36 + n_l36);
                n_cf[2] = n_l36;
                n_cf[3] = n_h36 + n_h36 - n_l36 - n_l36;
                n_cf[4] = n_h36 + n_h36 + n_l36 + n_l36 - ONE_COEF;
            end
            default: begin
            end
        endcase

        n_out_free = !r_ovalid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_mode       <= MODE_LPF1;
            r_cut1       <= 20'd10;
            r_cut2       <= 20'd10;
            r_period     <= 30'd1000000;
            r_cvalid     <= 1'b0;
            r_x1         <= '0;
            r_x2         <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_ovalid     <= 1'b0;
            r_dreq.start <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_prod       <= r_ma * r_mb;
            r_dreq.start <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x   <= s_axis_tdata[SAMPLE_BITS-1:0];
                        r_k   <= '0;
                        r_sel <= 1'b0;
                        if (r_cvalid) begin
                            r_state <= S_MAC;
                        end else if (n_defined) begin
                            r_state <= S_U0;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end
                end
                // u = floor(f * T * pi_q25 / 2e9), capped
                S_U0: begin
                    r_ma    <= 33'(n_f);
                    r_mb    <= 33'(r_period);
                    r_state <= S_U1;
                end
                S_U1: r_state <= S_U2;
                S_U2: begin
                    if (r_prod[63:0] >= P_CAP) begin
                        r_q     <= U_CAP;
                        r_state <= S_UCAP;
                    end else begin
                        r_pp    <= r_prod[35:0];
                        r_ma    <= 33'(r_prod[35:18]);
                        r_mb    <= 33'(PI_Q25);
                        r_state <= S_U3;
                    end
                end
                S_U3: begin
                    r_ma    <= 33'(r_pp[17:0]);
                    r_state <= S_U4;
                end
                S_U4: begin
                    r_acc   <= 68'(r_prod) <<< 18;
                    r_state <= S_U5;
                end
                // /2e9 is >>10 then /5^9; the reciprocal estimate is low by at most 4
                S_U5: begin
                    r_rem   <= n_pn >> 10;
                    r_ma    <= 33'(n_pn[62:31]);
                    r_mb    <= 33'(RECIP_5P9);
                    r_state <= S_U6;
                end
                S_U6: r_state <= S_U7;
                S_U7: begin
                    r_q     <= 64'(r_prod[62:31]);
                    r_ma    <= 33'(r_prod[62:31]);
                    r_mb    <= 33'(FIVE_P9);
                    r_state <= S_U8;
                end
                S_U8: r_state <= S_U9;
                S_U9: begin
                    r_rem   <= r_rem - r_prod[63:0];
                    r_state <= S_UFIX;
                end
                S_UFIX: begin
                    if (r_rem >= FIVE_P9) begin
                        r_rem <= r_rem - FIVE_P9;
                        r_q   <= r_q + 64'd1;
                    end else begin
                        r_state <= S_UCAP;
                    end
                end
                S_UCAP: begin
                    if (r_sel) begin
                        r_v <= n_ucap[31:0];
                    end else begin
                        r_u <= n_ucap[31:0];
                    end
                    if (n_second && !r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= S_U0;
                    end else if (n_second) begin
                        r_state <= S_P0;
                    end else begin
                        r_state <= S_C1;
                    end
                end
                S_DIVW: begin
                    if (w_drsp.done) begin
                        r_q     <= w_drsp.quo;
                        r_state <= r_ret;
                    end
                end
                // first order: c = frac(x, 2^48 + x)
                S_C1: begin
                    if (n_fn >= n_fd) begin
                        r_q     <= ONE_Q;
                        r_state <= S_C1P;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.rem0  <= n_fn;
                        r_dreq.num   <= '0;
                        r_dreq.den   <= n_fd;
                        r_dreq.iters <= FRAC_IT;
                        r_ret        <= S_C1P;
                        r_state      <= S_DIVW;
                    end
                end
                S_C1P: begin
                    r_c <= r_q[30:0];
                    if (r_mode == MODE_DERIV) begin
                        r_ma    <= 33'(r_q[30:0]);
                        r_mb    <= 33'(TWO_E9);
                        r_state <= S_D1;
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_D1: r_state <= S_D2;
                S_D2: begin
                    if (r_period == '0) begin
                        r_b0    <= '0;
                        r_state <= S_STORE;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.rem0  <= '0;
                        r_dreq.num   <= r_prod[63:0];
                        r_dreq.den   <= 64'(r_period);
                        r_dreq.iters <= DIV_FULL_IT;
                        r_ret        <= S_D3;
                        r_state      <= S_DIVW;
                    end
                end
                S_D3: begin
                    r_b0    <= (r_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_q[30:0];
                    r_state <= S_STORE;
                end
                // second order: P = u v, D = 2^48 + (u + v) 2^24 + P
                S_P0: begin
                    r_ma    <= 33'(r_u);
                    r_mb    <= 33'(r_v);
                    r_state <= S_P1;
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_p2    <= r_prod[63:0];
                    r_dd    <= ONE_Q48 + ((64'(r_u) + 64'(r_v)) << 24) + r_prod[63:0];
                    r_state <= S_P3;
                end
                S_P3, S_HL: begin
                    if (r_state == S_HL) begin
                        r_h <= r_q[30:0];
                    end
                    if (n_fn >= n_fd) begin
                        r_q     <= ONE_Q;
                        r_state <= (r_state == S_P3) ? S_HL : S_LST;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.rem0  <= n_fn;
                        r_dreq.num   <= '0;
                        r_dreq.den   <= n_fd;
                        r_dreq.iters <= FRAC_IT;
                        r_ret        <= (r_state == S_P3) ? S_HL : S_LST;
                        r_state      <= S_DIVW;
                    end
                end
                S_LST: begin
                    r_l     <= r_q[30:0];
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    for (int i = 0; i < 5; i++) begin
                        r_coef[i] <= sat32(n_cf[i]);
                    end
                    r_cvalid <= 1'b1;
                    r_k      <= '0;
                    r_state  <= S_MAC;
                end
                // each product passes through r_ma/r_mb, then r_prod, before it is accumulated
                S_MAC: begin
                    r_ma <= n_mac_a;
                    r_mb <= n_mac_b;
                    if (r_k == 3'd2) begin
                        r_acc <= 68'(r_prod);
                    end else if (r_k > 3'd2) begin
                        r_acc <= r_acc + 68'(r_prod);
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd6) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= n_ys[SAMPLE_BITS-1:0];
                        r_osat   <= (n_ys != n_y);
                        r_x2     <= r_x1;
                        r_x1     <= r_x;
                        r_y2     <= r_y1;
                        r_y1     <= n_y32[31:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_wr_en) begin
                r_cvalid <= 1'b0;
                unique case (i_cfg_addr)
                    REG_MODE:   r_mode   <= i_cfg_wdata[2:0];
                    REG_CUT1:   r_cut1   <= i_cfg_wdata[19:0];
                    REG_CUT2:   r_cut2   <= i_cfg_wdata[19:0];
                    REG_PERIOD: r_period <= i_cfg_wdata;
                    default:    r_mode   <= r_mode;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = DATA_W'(r_odata);
    assign m_axis_tuser  = r_osat;

endmodule
